>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hve assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HVE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hve assertion failed");

`endif

>>> rtl/hve_pkg.sv
// Package with shared constants, lookup tables and step functions of the encoder.
`timescale 1ns / 1ps
package hve_pkg;

   localparam int DIV_STAGES = 8;
   localparam int FREQ_STAGES = 8;
   localparam int AMP_STAGES = 4;
   localparam int PIPE_DEPTH = 1 + DIV_STAGES + AMP_STAGES;

   localparam logic [31:0] IDLE_RESET = 32'h4040_0100;
   localparam logic [16:0] AMP_ONE = 17'd32768;
   localparam logic [7:0] HIGH_FREQ_OFFSET = 8'h60;
   localparam logic [7:0] LOW_FREQ_OFFSET = 8'h40;
   localparam logic [7:0] LOW_AMP_BASE = 8'h40;
   localparam logic [6:0] AMP_LAST_INDEX = 7'd100;

   typedef logic [15:0] freq_thr_type [256];
   typedef logic [15:0] amp_max_type [128];

   typedef struct packed {
      logic        idle;
      logic        scale;
      logic [15:0] high_amp;
      logic [15:0] low_amp;
   } side_type;

   typedef struct packed {
      logic       idle;
      logic [7:0] high_code;
      logic [7:0] low_code;
   } tail_type;

   localparam logic [9:0] AMP_THR_MILLI [101] = '{
      10'd0, 10'd10, 10'd12, 10'd14, 10'd17, 10'd20, 10'd24, 10'd28, 10'd33, 10'd40,
      10'd47, 10'd56, 10'd67, 10'd80, 10'd95, 10'd112, 10'd117, 10'd123, 10'd128,
      10'd134, 10'd140, 10'd146, 10'd152, 10'd159, 10'd166, 10'd173, 10'd181, 10'd189,
      10'd198, 10'd206, 10'd215, 10'd225, 10'd230, 10'd235, 10'd240, 10'd245, 10'd251,
      10'd256, 10'd262, 10'd268, 10'd273, 10'd279, 10'd286, 10'd292, 10'd298, 10'd305,
      10'd311, 10'd318, 10'd325, 10'd332, 10'd340, 10'd347, 10'd355, 10'd362, 10'd370,
      10'd378, 10'd387, 10'd395, 10'd404, 10'd413, 10'd422, 10'd431, 10'd440, 10'd450,
      10'd460, 10'd470, 10'd480, 10'd491, 10'd501, 10'd512, 10'd524, 10'd535, 10'd547,
      10'd559, 10'd571, 10'd584, 10'd596, 10'd609, 10'd623, 10'd636, 10'd650, 10'd665,
      10'd679, 10'd694, 10'd709, 10'd725, 10'd741, 10'd757, 10'd773, 10'd790, 10'd808,
      10'd825, 10'd843, 10'd862, 10'd881, 10'd900, 10'd920, 10'd940, 10'd960, 10'd981,
      10'd1003
   };

   // True when f^32 >= 5^32 * 2^(160+k), the exact form of f/16 >= 10 * 2^(k/32).
   function automatic logic freq_pow_ge(input logic [15:0] f, input int k);
      logic [511:0] p;
      logic [511:0] q;
      p = 512'(f);
      q = 512'd5;
      for (int n = 0; n < 5; n++) begin
         p = p * p;
         q = q * q;
      end
      q = q << (160 + k);
      return p >= q;
   endfunction

   // Smallest frequency that reaches each code.
   function automatic freq_thr_type build_freq_thr();
      freq_thr_type t;
      int lo;
      int hi;
      int mid;
      for (int k = 0; k < 256; k++) begin
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (freq_pow_ge(16'(mid), k)) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         t[k] = 16'(lo);
      end
      return t;
   endfunction

   // Largest amplitude that still selects each threshold entry.
   function automatic amp_max_type build_amp_max();
      amp_max_type m;
      for (int i = 0; i < 128; i++) begin
         if (i < 101) begin
            m[i] = 16'((32'(AMP_THR_MILLI[i]) * 32'd32768) / 32'd1000);
         end else begin
            m[i] = 16'hFFFF;
         end
      end
      return m;
   endfunction

   localparam freq_thr_type FREQ_THR = build_freq_thr();
   localparam amp_max_type AMP_MAX = build_amp_max();

   // One restoring division step: quotient bit on top, new remainder below.
   function automatic logic [17:0] div_step(input logic [16:0] rem, input logic [16:0] den,
                                            input logic bit_in);
      logic [17:0] sh;
      logic [17:0] diff;
      sh = {rem, bit_in};
      diff = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         return {1'b1, diff[16:0]};
      end
      return {1'b0, sh[16:0]};
   endfunction

   // One binary search step over the amplitude thresholds.
   function automatic logic [6:0] amp_step(input logic [15:0] amp, input logic [6:0] cnt,
                                           input logic [6:0] mask);
      logic [6:0] cand;
      cand = cnt | mask;
      if (AMP_MAX[cand - 7'd1] < amp) begin
         return cand;
      end
      return cnt;
   endfunction

endpackage

>>> rtl/hve_divider.sv
// Pipelined restoring divider computing floor(amp * 32768 / sum), two bits per stage.
`timescale 1ns / 1ps
module hve_divider (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] num,
   input  logic [16:0] den,
   output logic [15:0] quo
);

   logic [16:0] rem_ff [hve_pkg::DIV_STAGES];
   logic [15:0] quo_ff [hve_pkg::DIV_STAGES];
   logic [16:0] den_ff [hve_pkg::DIV_STAGES];

   for (genvar s = 0; s < hve_pkg::DIV_STAGES; s++) begin : g_stage
      logic [16:0] rem_prev;
      logic [15:0] quo_prev;
      logic [16:0] den_prev;
      logic        first_bit;
      logic [17:0] step_a;
      logic [17:0] step_b;
      logic [16:0] rem_in;
      logic [15:0] quo_in;

      if (s == 0) begin : g_head
         assign rem_prev = {2'b00, num[15:1]};
         assign quo_prev = '0;
         assign den_prev = den;
         assign first_bit = num[0];
      end else begin : g_body
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign first_bit = 1'b0;
      end

      always_comb begin
         step_a = hve_pkg::div_step(rem_prev, den_prev, first_bit);
         step_b = hve_pkg::div_step(step_a[16:0], den_prev, 1'b0);
         rem_in = step_b[16:0];
         quo_in = {quo_prev[13:0], step_a[17], step_b[17]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
            den_ff[s] <= den_prev;
         end
      end
   end

   assign quo = quo_ff[hve_pkg::DIV_STAGES-1];

endmodule

>>> rtl/hve_freq_search.sv
// Pipelined binary search of the logarithmic frequency code, one bit per stage.
`timescale 1ns / 1ps
module hve_freq_search (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] freq,
   output logic [7:0]  code
);

   logic [15:0] freq_ff [hve_pkg::FREQ_STAGES];
   logic [7:0]  code_ff [hve_pkg::FREQ_STAGES];

   for (genvar s = 0; s < hve_pkg::FREQ_STAGES; s++) begin : g_stage
      localparam logic [7:0] MASK = 8'(1 << (hve_pkg::FREQ_STAGES - 1 - s));
      logic [15:0] freq_prev;
      logic [7:0]  code_prev;
      logic [7:0]  cand;
      logic [7:0]  code_in;

      if (s == 0) begin : g_head
         assign freq_prev = freq;
         assign code_prev = '0;
      end else begin : g_body
         assign freq_prev = freq_ff[s-1];
         assign code_prev = code_ff[s-1];
      end

      always_comb begin
         cand = code_prev | MASK;
         code_in = (hve_pkg::FREQ_THR[cand] <= freq_prev) ? cand : code_prev;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            freq_ff[s] <= freq_prev;
            code_ff[s] <= code_in;
         end
      end
   end

   assign code = code_ff[hve_pkg::FREQ_STAGES-1];

endmodule

>>> rtl/hve_amp_search.sv
// Pipelined binary search of the amplitude threshold index, two bits per stage but one in the last stage.
`timescale 1ns / 1ps
module hve_amp_search (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] amp,
   output logic [6:0]  index
);

   logic [15:0] amp_ff [hve_pkg::AMP_STAGES];
   logic [6:0]  cnt_ff [hve_pkg::AMP_STAGES];

   for (genvar s = 0; s < hve_pkg::AMP_STAGES; s++) begin : g_stage
      localparam int HI_BIT = 6 - 2 * s;
      localparam logic [6:0] MASK_A = 7'(1 << HI_BIT);
      logic [15:0] amp_prev;
      logic [6:0]  cnt_prev;
      logic [6:0]  cnt_a;
      logic [6:0]  cnt_in;

      if (s == 0) begin : g_head
         assign amp_prev = amp;
         assign cnt_prev = '0;
      end else begin : g_body
         assign amp_prev = amp_ff[s-1];
         assign cnt_prev = cnt_ff[s-1];
      end

      assign cnt_a = hve_pkg::amp_step(amp_prev, cnt_prev, MASK_A);

      if (HI_BIT > 0) begin : g_pair
         localparam logic [6:0] MASK_B = 7'(1 << (HI_BIT - 1));
         assign cnt_in = hve_pkg::amp_step(amp_prev, cnt_a, MASK_B);
      end else begin : g_single
         assign cnt_in = cnt_a;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            amp_ff[s] <= amp_prev;
            cnt_ff[s] <= cnt_in;
         end
      end
   end

   assign index = (cnt_ff[hve_pkg::AMP_STAGES-1] > hve_pkg::AMP_LAST_INDEX) ?
                  hve_pkg::AMP_LAST_INDEX : cnt_ff[hve_pkg::AMP_STAGES-1];

endmodule

>>> rtl/haptic_vibration_encoder.sv
// Top level of the two-band haptic drive report encoder.
// The req channel carries one beat per vibration request: high and low band
// frequency (1/16 Hz) and amplitude (Q1.15). The rsp channel returns one
// 64-bit drive report per request, in request order; bytes 4 to 7 repeat
// bytes 0 to 3. When both amplitudes are zero the report is the idle
// pattern register, written through csr_write_en and csr_write_data.
// A beat accepted on req passes through one input stage, eight stages of
// the amplitude scaling divider (run in parallel with the frequency code
// search), four stages of amplitude threshold search, and the output
// register before it shows up on rsp.
// Throughput is one beat per cycle unless rsp stalls. The whole pipeline
// advances together, so a stall on rsp_ready freezes every stage and
// deasserts req_ready; nothing is dropped or repeated.
// Reset empties the pipeline and loads the idle pattern with 0x40400100.
`timescale 1ns / 1ps
module haptic_vibration_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_high_freq,
   input  logic [15:0] req_high_amp,
   input  logic [15:0] req_low_freq,
   input  logic [15:0] req_low_amp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_report,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   logic                              en;
   logic [31:0]                       idle_pattern_ff;
   logic [hve_pkg::PIPE_DEPTH-1:0]    vld_ff;
   logic                              rsp_valid_ff;
   logic [63:0]                       rsp_report_ff;
   logic [63:0]                       rsp_report_in;
   logic [15:0]                       high_freq_ff;
   logic [15:0]                       low_freq_ff;
   logic [16:0]                       sum_ff;
   hve_pkg::side_type                 s0_side_ff;
   hve_pkg::side_type                 s0_side_in;
   logic [16:0]                       sum_in;
   hve_pkg::side_type                 side_ff [hve_pkg::DIV_STAGES];
   hve_pkg::tail_type                 tail_ff [hve_pkg::AMP_STAGES];
   hve_pkg::tail_type                 tail_in;
   logic [15:0]                       high_quo;
   logic [15:0]                       low_quo;
   logic [7:0]                        high_code;
   logic [7:0]                        low_code;
   logic [15:0]                       high_amp_sel;
   logic [15:0]                       low_amp_sel;
   logic [6:0]                        high_index;
   logic [6:0]                        low_index;
   logic [7:0]                        high_diff;
   logic [8:0]                        hf;
   logic [7:0]                        lf;
   logic [31:0]                       word;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_report = rsp_report_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_pattern_ff <= hve_pkg::IDLE_RESET;
      end else if (csr_write_en) begin
         idle_pattern_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[hve_pkg::PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[hve_pkg::PIPE_DEPTH-1];
      end
   end

   always_comb begin
      sum_in = {1'b0, req_high_amp} + {1'b0, req_low_amp};
      s0_side_in.idle = (req_high_amp == '0) && (req_low_amp == '0);
      s0_side_in.scale = sum_in > hve_pkg::AMP_ONE;
      s0_side_in.high_amp = req_high_amp;
      s0_side_in.low_amp = req_low_amp;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         high_freq_ff <= req_high_freq;
         low_freq_ff <= req_low_freq;
         sum_ff <= sum_in;
         s0_side_ff <= s0_side_in;
      end
   end

   hve_divider u_high_div (
      .clock (clock),
      .en    (en),
      .num   (s0_side_ff.high_amp),
      .den   (sum_ff),
      .quo   (high_quo)
   );

   hve_divider u_low_div (
      .clock (clock),
      .en    (en),
      .num   (s0_side_ff.low_amp),
      .den   (sum_ff),
      .quo   (low_quo)
   );

   hve_freq_search u_high_freq (
      .clock (clock),
      .en    (en),
      .freq  (high_freq_ff),
      .code  (high_code)
   );

   hve_freq_search u_low_freq (
      .clock (clock),
      .en    (en),
      .freq  (low_freq_ff),
      .code  (low_code)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s0_side_ff;
         for (int s = 1; s < hve_pkg::DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      high_amp_sel = side_ff[hve_pkg::DIV_STAGES-1].scale ?
                     high_quo : side_ff[hve_pkg::DIV_STAGES-1].high_amp;
      low_amp_sel = side_ff[hve_pkg::DIV_STAGES-1].scale ?
                    low_quo : side_ff[hve_pkg::DIV_STAGES-1].low_amp;
      tail_in.idle = side_ff[hve_pkg::DIV_STAGES-1].idle;
      tail_in.high_code = high_code;
      tail_in.low_code = low_code;
   end

   hve_amp_search u_high_amp (
      .clock (clock),
      .en    (en),
      .amp   (high_amp_sel),
      .index (high_index)
   );

   hve_amp_search u_low_amp (
      .clock (clock),
      .en    (en),
      .amp   (low_amp_sel),
      .index (low_index)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         tail_ff[0] <= tail_in;
         for (int s = 1; s < hve_pkg::AMP_STAGES; s++) begin
            tail_ff[s] <= tail_ff[s-1];
         end
      end
   end

   always_comb begin
      high_diff = tail_ff[hve_pkg::AMP_STAGES-1].high_code - hve_pkg::HIGH_FREQ_OFFSET;
      hf = {high_diff[6:0], 2'b00};
      lf = tail_ff[hve_pkg::AMP_STAGES-1].low_code - hve_pkg::LOW_FREQ_OFFSET;
      word[7:0] = hf[7:0];
      word[15:8] = {high_index, 1'b0} | {7'd0, hf[8]};
      word[23:16] = lf | {low_index[0], 7'd0};
      word[31:24] = hve_pkg::LOW_AMP_BASE + {2'b00, low_index[6:1]};
      if (tail_ff[hve_pkg::AMP_STAGES-1].idle) begin
         rsp_report_in = {idle_pattern_ff, idle_pattern_ff};
      end else begin
         rsp_report_in = {word, word};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_report_ff <= rsp_report_in;
      end
   end

endmodule

>>> rtl/hve_checker.sv
// Port-level checker for the encoder and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hve_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_report
);

   `HVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_report))
   `HVE_ASSERT_SAME(a_halves_match, clock, reset, rsp_valid, rsp_report[63:32] == rsp_report[31:0])
   `HVE_ASSERT_SAME(a_ready_when_free, clock, reset, !rsp_valid || rsp_ready, req_ready)
   `HVE_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind haptic_vibration_encoder hve_checker u_hve_checker (.*);
